// ===== src/alpha_smoothstep_remap_bbox_macros.svh =====
// Assertion shorthands used by the checker of this block.
`ifndef ALPHA_SMOOTHSTEP_REMAP_BBOX_MACROS_SVH
`define ALPHA_SMOOTHSTEP_REMAP_BBOX_MACROS_SVH

// Same-cycle implication.
`define ASSRB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSRB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/assrb_pkg.sv =====
package assrb_pkg;

   localparam int MAX_DIM       = 4096;
   localparam int TABLE_ENTRIES = 256;
   localparam int CNT_W         = $clog2(MAX_DIM);
   localparam int DIM_W         = CNT_W + 1;
   localparam int PIX_W         = $clog2(TABLE_ENTRIES);
   localparam int CH_W          = 3;
   localparam int STATUS_W      = 2;
   localparam int REG_IDX_W     = 3;
   localparam int CSR_ADDR_W    = REG_IDX_W + 2;
   localparam int CSR_DATA_W    = 32;

   localparam logic [REG_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_HIGH_THRESHOLD = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ADJUST_ENABLE  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_RECT_ENABLE    = 3'd6;

   localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CHANNELS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DISABLED     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY_BOX    = 2'd3;

   localparam logic [CH_W-1:0] CH_ONE   = 3'd1;
   localparam logic [CH_W-1:0] CH_THREE = 3'd3;
   localparam logic [CH_W-1:0] CH_FOUR  = 3'd4;

   localparam logic [PIX_W-1:0] RST_LOW_THRESHOLD  = 8'd60;
   localparam logic [PIX_W-1:0] RST_HIGH_THRESHOLD = 8'd220;
   localparam logic [DIM_W-1:0] RST_IMAGE_DIM      = DIM_W'(1);
   localparam logic [CH_W-1:0]  RST_CHANNEL_COUNT  = CH_FOUR;

   typedef struct packed {
      logic [PIX_W-1:0] alpha_in;
      logic [PIX_W-1:0] fourth_channel;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]    mapped_value;
      logic [PIX_W-1:0]    channel3_out;
      logic [CNT_W-1:0]    rect_x;
      logic [CNT_W-1:0]    rect_y;
      logic [DIM_W-1:0]    rect_w;
      logic [DIM_W-1:0]    rect_h;
      logic [STATUS_W-1:0] status;
      logic                frame_last;
   } rsp_type;

   typedef struct packed {
      logic [PIX_W-1:0] low_threshold;
      logic [PIX_W-1:0] high_threshold;
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
      logic [CH_W-1:0]  channel_count;
      logic             adjust_enable;
      logic             rect_enable;
   } cfg_type;

   typedef struct packed {
      logic             en;
      logic [PIX_W-1:0] addr;
      logic [PIX_W-1:0] data;
   } tbl_wr_type;

   // Zero acts as one, anything past the maximum acts as the maximum.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== src/assrb_table_build.sv =====
module assrb_table_build (
   input  logic                 clock,
   input  logic                 reset,
   input  assrb_pkg::cfg_type   cfg,
   input  logic                 start,
   output assrb_pkg::tbl_wr_type tbl_wr,
   output logic                 busy
);
   import assrb_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SQUARE = 3'd1;
   localparam logic [2:0] ST_CUBE   = 3'd2;
   localparam logic [2:0] ST_SCALE  = 3'd3;
   localparam logic [2:0] ST_DIVIDE = 3'd4;
   localparam logic [2:0] ST_WRITE  = 3'd5;

   localparam int SQ_W   = 2 * PIX_W;
   localparam int SUB_W  = PIX_W + 2;
   localparam int P1_W   = SQ_W + SUB_W;
   localparam int CUBE_W = 3 * PIX_W;
   localparam int NUM_W  = P1_W + PIX_W;
   localparam int DSH_W  = CUBE_W + PIX_W;
   localparam int Q_W    = PIX_W + 1;
   localparam int DC_W   = $clog2(PIX_W + 1);

   logic [2:0]       state_ff, state_in;
   logic [PIX_W-1:0] idx_ff, idx_in;
   logic [DC_W-1:0]  div_cnt_ff, div_cnt_in;

   logic [SQ_W-1:0]   nn_ff, dd_ff;
   logic [SUB_W-1:0]  sub_ff;
   logic [PIX_W-1:0]  d_ff;
   logic              in_range_ff, below_ff;
   logic [P1_W-1:0]   p1_ff;
   logic [CUBE_W-1:0] ddd_ff;
   logic [NUM_W-1:0]  rem_ff;
   logic [DSH_W-1:0]  dsh_ff;
   logic [Q_W-1:0]    q_ff;

   logic [PIX_W-1:0] n, d;
   logic [SUB_W-1:0] d3, n2;
   logic             fits;

   assign n    = idx_ff - cfg.low_threshold;
   assign d    = cfg.high_threshold - cfg.low_threshold;
   assign d3   = {2'b00, d} + {1'b0, d, 1'b0};
   assign n2   = {1'b0, n, 1'b0};
   assign fits = rem_ff >= {{(NUM_W-DSH_W){1'b0}}, dsh_ff};

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      div_cnt_in = div_cnt_ff;
      case (state_ff)
         ST_IDLE:   state_in = ST_IDLE;
         ST_SQUARE: state_in = ST_CUBE;
         ST_CUBE:   state_in = ST_SCALE;
         ST_SCALE: begin
            state_in   = ST_DIVIDE;
            div_cnt_in = DC_W'(PIX_W);
         end
         ST_DIVIDE: begin
            if (div_cnt_ff == '0) begin
               state_in = ST_WRITE;
            end else begin
               div_cnt_in = div_cnt_ff - DC_W'(1);
            end
         end
         ST_WRITE: begin
            idx_in   = idx_ff + PIX_W'(1);
            state_in = (idx_ff == PIX_W'(TABLE_ENTRIES - 1)) ? ST_IDLE : ST_SQUARE;
         end
         default:   state_in = ST_IDLE;
      endcase
      // a threshold write restarts the sweep from the first entry
      if (start) begin
         state_in = ST_SQUARE;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SQUARE;
         idx_ff     <= '0;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_SQUARE: begin
            nn_ff       <= {{PIX_W{1'b0}}, n} * {{PIX_W{1'b0}}, n};
            dd_ff       <= {{PIX_W{1'b0}}, d} * {{PIX_W{1'b0}}, d};
            sub_ff      <= d3 - n2;
            d_ff        <= d;
            in_range_ff <= (idx_ff > cfg.low_threshold) && (idx_ff < cfg.high_threshold);
            below_ff    <= idx_ff <= cfg.low_threshold;
         end
         ST_CUBE: begin
            p1_ff  <= {{SUB_W{1'b0}}, nn_ff} * {{SQ_W{1'b0}}, sub_ff};
            ddd_ff <= {{PIX_W{1'b0}}, dd_ff} * {{SQ_W{1'b0}}, d_ff};
         end
         ST_SCALE: begin
            // times 255 as a shift and subtract
            rem_ff <= {p1_ff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, p1_ff};
            dsh_ff <= {ddd_ff, {PIX_W{1'b0}}};
            q_ff   <= '0;
         end
         ST_DIVIDE: begin
            if (fits) begin
               rem_ff <= rem_ff - {{(NUM_W-DSH_W){1'b0}}, dsh_ff};
            end
            q_ff   <= {q_ff[Q_W-2:0], fits};
            dsh_ff <= dsh_ff >> 1;
         end
         default: ;
      endcase
   end

   always_comb begin
      tbl_wr.en   = state_ff == ST_WRITE;
      tbl_wr.addr = idx_ff;
      if (!in_range_ff) begin
         tbl_wr.data = below_ff ? '0 : '1;
      end else if (q_ff[Q_W-1]) begin
         tbl_wr.data = '1;
      end else begin
         tbl_wr.data = q_ff[PIX_W-1:0];
      end
   end

   assign busy = state_ff != ST_IDLE;

endmodule

// ===== src/assrb_pixel_path.sv =====
module assrb_pixel_path (
   input  logic                  clock,
   input  logic                  reset,
   input  assrb_pkg::cfg_type    cfg,
   input  logic                  frame_restart,
   input  assrb_pkg::tbl_wr_type tbl_wr,
   input  logic                  table_busy,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  assrb_pkg::req_type    req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output assrb_pkg::rsp_type    rsp_payload
);
   import assrb_pkg::*;

   logic [PIX_W-1:0] map_mem [TABLE_ENTRIES];

   logic             s1_valid_ff, s1_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   req_type          s1_item_ff;
   logic [PIX_W-1:0] lut_ff;
   rsp_type          rsp_ff, rsp_in;

   logic [CNT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [DIM_W-1:0] min_x_ff, min_x_in, min_y_ff, min_y_in;
   logic [CNT_W-1:0] max_x_ff, max_x_in, max_y_ff, max_y_in;

   logic out_free, s1_adv, accept;

   logic [DIM_W-1:0] w, h, x_ext, y_ext, x_inc, y_inc;
   logic [DIM_W-1:0] min_x_cur, min_y_cur;
   logic [CNT_W-1:0] max_x_cur, max_y_cur;
   logic             last_col, last_row, last, frame_start;
   logic             chan_ok, any_en, ok_path, hit, empty, show_box;
   logic [PIX_W-1:0] v;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_stall = table_busy || (s1_valid_ff && !out_free);
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (tbl_wr.en) begin
         map_mem[tbl_wr.addr] <= tbl_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lut_ff     <= map_mem[req_payload.alpha_in];
         s1_item_ff <= req_payload;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      w         = clamp_dim(cfg.image_width);
      h         = clamp_dim(cfg.image_height);
      x_ext     = {1'b0, col_ff};
      y_ext     = {1'b0, row_ff};
      x_inc     = x_ext + DIM_W'(1);
      y_inc     = y_ext + DIM_W'(1);
      last_col  = x_inc >= w;
      last_row  = y_inc >= h;
      last      = last_col && last_row;

      // first pixel of a frame reloads the box
      frame_start = (col_ff == '0) && (row_ff == '0);
      min_x_cur   = frame_start ? w  : min_x_ff;
      min_y_cur   = frame_start ? h  : min_y_ff;
      max_x_cur   = frame_start ? '0 : max_x_ff;
      max_y_cur   = frame_start ? '0 : max_y_ff;

      chan_ok = cfg.channel_count inside {CH_ONE, CH_THREE, CH_FOUR};
      any_en  = cfg.adjust_enable || cfg.rect_enable;
      ok_path = chan_ok && any_en;
      v       = cfg.adjust_enable ? lut_ff : s1_item_ff.alpha_in;
      hit     = ok_path && cfg.rect_enable && (v != '0);

      min_x_in = (hit && (x_ext < min_x_cur)) ? x_ext : min_x_cur;
      min_y_in = (hit && (y_ext < min_y_cur)) ? y_ext : min_y_cur;
      max_x_in = (hit && (col_ff > max_x_cur)) ? col_ff : max_x_cur;
      max_y_in = (hit && (row_ff > max_y_cur)) ? row_ff : max_y_cur;

      empty    = ({1'b0, max_x_in} <= min_x_in) || ({1'b0, max_y_in} <= min_y_in);
      show_box = ok_path && last && cfg.rect_enable && !empty;

      col_in = last_col ? '0 : x_inc[CNT_W-1:0];
      if (!last_col) begin
         row_in = row_ff;
      end else if (last_row) begin
         row_in = '0;
      end else begin
         row_in = y_inc[CNT_W-1:0];
      end

      if (!chan_ok) begin
         rsp_in.status = STATUS_BAD_CHANNELS;
      end else if (!any_en) begin
         rsp_in.status = STATUS_DISABLED;
      end else if (last && cfg.rect_enable && empty) begin
         rsp_in.status = STATUS_EMPTY_BOX;
      end else begin
         rsp_in.status = STATUS_OK;
      end
      rsp_in.mapped_value = (ok_path && cfg.adjust_enable) ? lut_ff : '0;
      rsp_in.channel3_out = (ok_path && cfg.adjust_enable && (cfg.channel_count == CH_FOUR))
                            ? s1_item_ff.fourth_channel : '0;
      rsp_in.rect_x       = show_box ? min_x_in[CNT_W-1:0] : '0;
      rsp_in.rect_y       = show_box ? min_y_in[CNT_W-1:0] : '0;
      rsp_in.rect_w       = show_box ? ({1'b0, max_x_in} - min_x_in + DIM_W'(1)) : '0;
      rsp_in.rect_h       = show_box ? ({1'b0, max_y_in} - min_y_in + DIM_W'(1)) : '0;
      rsp_in.frame_last   = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         min_x_ff     <= RST_IMAGE_DIM;
         min_y_ff     <= RST_IMAGE_DIM;
         max_x_ff     <= '0;
         max_y_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (frame_restart) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (s1_adv) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (s1_adv) begin
            min_x_ff <= min_x_in;
            min_y_ff <= min_y_in;
            max_x_ff <= max_x_in;
            max_y_ff <= max_y_in;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== src/alpha_smoothstep_remap_bbox.sv =====
// Pipeline: an accepted item is held in the input register with its table read, then
// moves into the result register once that register is free of a stalled item.
// Throughput: one item per cycle while neither a table rebuild nor rsp_stall holds it.
// Table rebuild: 256 entries, each through the square, cube, scale, divide and write
// states, after reset and after each threshold write; req_stall stays high meanwhile.
// Reset (synchronous, active high) loads register defaults, empties the pipeline
// and zeroes the pixel counters; the table rebuild starts as reset drops.
module alpha_smoothstep_remap_bbox (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  assrb_pkg::req_type                  req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output assrb_pkg::rsp_type                  rsp_payload,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [assrb_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [assrb_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [assrb_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);
   import assrb_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 csr_write;
   logic                 table_start;
   logic                 frame_restart;
   tbl_wr_type           tbl_wr;
   logic                 table_busy;

   // Register file: byte address four times the register index.
   assign pready    = 1'b1;
   assign reg_idx   = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   // Threshold writes retrigger the table sweep; dimension writes restart the frame.
   assign table_start   = csr_write && ((reg_idx == REG_LOW_THRESHOLD) ||
                                        (reg_idx == REG_HIGH_THRESHOLD));
   assign frame_restart = csr_write && ((reg_idx == REG_IMAGE_WIDTH) ||
                                        (reg_idx == REG_IMAGE_HEIGHT));

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_idx)
            REG_LOW_THRESHOLD:  cfg_in.low_threshold  = pwdata[PIX_W-1:0];
            REG_HIGH_THRESHOLD: cfg_in.high_threshold = pwdata[PIX_W-1:0];
            REG_IMAGE_WIDTH:    cfg_in.image_width    = pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT:   cfg_in.image_height   = pwdata[DIM_W-1:0];
            REG_CHANNEL_COUNT:  cfg_in.channel_count  = pwdata[CH_W-1:0];
            REG_ADJUST_ENABLE:  cfg_in.adjust_enable  = pwdata[0];
            REG_RECT_ENABLE:    cfg_in.rect_enable    = pwdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_threshold  <= RST_LOW_THRESHOLD;
         cfg_ff.high_threshold <= RST_HIGH_THRESHOLD;
         cfg_ff.image_width    <= RST_IMAGE_DIM;
         cfg_ff.image_height   <= RST_IMAGE_DIM;
         cfg_ff.channel_count  <= RST_CHANNEL_COUNT;
         cfg_ff.adjust_enable  <= 1'b1;
         cfg_ff.rect_enable    <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Readback, zero extended.
   always_comb begin
      case (reg_idx)
         REG_LOW_THRESHOLD:  prdata = CSR_DATA_W'(cfg_ff.low_threshold);
         REG_HIGH_THRESHOLD: prdata = CSR_DATA_W'(cfg_ff.high_threshold);
         REG_IMAGE_WIDTH:    prdata = CSR_DATA_W'(cfg_ff.image_width);
         REG_IMAGE_HEIGHT:   prdata = CSR_DATA_W'(cfg_ff.image_height);
         REG_CHANNEL_COUNT:  prdata = CSR_DATA_W'(cfg_ff.channel_count);
         REG_ADJUST_ENABLE:  prdata = CSR_DATA_W'(cfg_ff.adjust_enable);
         REG_RECT_ENABLE:    prdata = CSR_DATA_W'(cfg_ff.rect_enable);
         default:            prdata = '0;
      endcase
   end

   // Smoothstep table: one entry at a time through a multiply chain and a
   // restoring divider, written into the lookup memory of the pixel path.
   assrb_table_build u_table_build (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .start  (table_start),
      .tbl_wr (tbl_wr),
      .busy   (table_busy)
   );

   // Pixel path: table read with the input register, then box tracking,
   // status and frame counters ahead of the result register.
   assrb_pixel_path u_pixel_path (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .frame_restart (frame_restart),
      .tbl_wr        (tbl_wr),
      .table_busy    (table_busy),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload)
   );

endmodule

// ===== src/assrb_checker.sv =====
`include "alpha_smoothstep_remap_bbox_macros.svh"

module assrb_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input assrb_pkg::rsp_type rsp_payload
);
   import assrb_pkg::*;

   `ASSRB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result item changed")

   `ASSRB_ASSERT_NOW(a_bad_ch_zero, clock, reset, rsp_valid && (rsp_payload.status == STATUS_BAD_CHANNELS), (rsp_payload.mapped_value == 0) && (rsp_payload.channel3_out == 0) && (rsp_payload.rect_w == 0) && (rsp_payload.rect_h == 0), "bad channel count item carries values")

   `ASSRB_ASSERT_NOW(a_box_only_last, clock, reset, rsp_valid && !rsp_payload.frame_last, (rsp_payload.rect_w == 0) && (rsp_payload.rect_h == 0) && (rsp_payload.status != STATUS_EMPTY_BOX), "box reported before last pixel")

   `ASSRB_ASSERT_NOW(a_box_size, clock, reset, rsp_valid && (rsp_payload.rect_w != 0), (rsp_payload.rect_w >= 2) && (rsp_payload.rect_h >= 2) && (rsp_payload.status == STATUS_OK), "reported box is too thin")

endmodule

bind alpha_smoothstep_remap_bbox assrb_checker u_assrb_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
